/* rtl/core/aes128_pkg.sv */
// Shared types, tables and round functions for the AES-128 encryption pipeline.
package aes128_pkg;

	typedef logic [127:0] blk_t;

	localparam int Rounds = 10;

	// Register indexes on the configuration port.
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [Rounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// SubBytes and ShiftRows; byte 0 sits in bits 127:120.
	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		logic [3:0] src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = 4'((4 * ((c + r) & 3) + r) & 15);
				t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * src -: 8]];
			end
		end
		return t;
	endfunction

	function automatic blk_t mix(input blk_t s);
		blk_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 8 * (4 * c)     -: 8];
			a1 = s[127 - 8 * (4 * c + 1) -: 8];
			a2 = s[127 - 8 * (4 * c + 2) -: 8];
			a3 = s[127 - 8 * (4 * c + 3) -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 8 * (4 * c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[127 - 8 * (4 * c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[127 - 8 * (4 * c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[127 - 8 * (4 * c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// One step of the key schedule: RotWord, SubWord, Rcon, then the word chain.
	function automatic blk_t key_next(input blk_t k, input logic [7:0] rcon);
		logic [31:0] t, w0, w1, w2, w3;
		t  = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

/* rtl/core/aes128_block_encrypt.sv */
// AES-128 block encryption, fully unrolled round pipeline.
//
// Usage:
//   Load the key through the write port: index 0 takes key bytes 0..7, index 1
//   takes key bytes 8..15 (byte 0 in the top bits). Write it only while no block
//   is in flight. Both key halves reset to zero.
//   Present a plaintext block on plain_high/plain_low with in_valid; a transfer
//   occurs when in_valid and in_ready are both high. Ciphertext leaves on
//   cipher_high/cipher_low with out_valid and transfers when out_ready is high.
// Timing:
//   Eleven register stages: the initial AddRoundKey, then one stage per round.
//   One block enters every cycle while in_ready is high. Each round stage does the
//   S-box lookups, MixColumns (skipped in the final round) and the round-key add,
//   with the round key expanded alongside in the same stage.
// Reset and stall:
//   arst_n clears all stage valid bits and the key. When out_ready drops, each
//   stage holds while every stage after it is full; bubbles still close up, so
//   the pipe keeps taking input until every stage is occupied.
module aes128_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	localparam int Last = aes128_pkg::Rounds;

	logic [63:0] key_hi_q, key_lo_q;

	// Stage 0 holds the whitened block; stage r holds the state after round r.
	aes128_pkg::blk_t blk_s [0:Last];
	aes128_pkg::blk_t key_s [0:Last];
	logic [Last:0]    vld_s;
	logic [Last:0]    rdy;

	// Key registers: drop writes into the matching half.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aes128_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
				aes128_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or its contents advance this cycle.
	always_comb begin
		rdy[Last] = !vld_s[Last] || out_ready;
		for (int i = Last - 1; i >= 0; i--) begin
			rdy[i] = !vld_s[i] || rdy[i + 1];
		end
	end

	assign in_ready = rdy[0];

	// Stage 0: initial AddRoundKey with the cipher key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			blk_s[0] <= {plain_high, plain_low} ^ {key_hi_q, key_lo_q};
			key_s[0] <= {key_hi_q, key_lo_q};
		end
	end

	// Round stages; the key travels with its block so a later key write
	// never disturbs blocks already inside.
	for (genvar r = 1; r <= Last; r++) begin : g_round
		aes128_pkg::blk_t rkey, sstate, nstate;

		always_comb begin
			rkey   = aes128_pkg::key_next(key_s[r - 1], aes128_pkg::RCON[r - 1]);
			sstate = aes128_pkg::sub_shift(blk_s[r - 1]);
			if (r < Last) begin
				nstate = aes128_pkg::mix(sstate) ^ rkey;
			end else begin
				nstate = sstate ^ rkey;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r] <= 1'b0;
			end else if (rdy[r]) begin
				vld_s[r] <= vld_s[r - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[r] && vld_s[r - 1]) begin
				blk_s[r] <= nstate;
				key_s[r] <= rkey;
			end
		end
	end

	assign out_valid   = vld_s[Last];
	assign cipher_high = blk_s[Last][127:64];
	assign cipher_low  = blk_s[Last][63:0];

endmodule
